// File: rtl/core/brq_pkg.sv
`default_nettype none

package brq_pkg;

    localparam int PORTS      = 32;
    localparam int RING_DEPTH = 1024;
    localparam int WORD_WIDTH = 32;

    // Stored word width: the handle field is 32 bits wide.
    localparam int WORD_W    = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;
    localparam int PIDX_W    = $clog2(PORTS);
    localparam int RPTR_W    = $clog2(RING_DEPTH);
    localparam int ID_W      = $clog2(PORTS + 1);
    localparam int RAM_DEPTH = PORTS * RING_DEPTH;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    localparam logic [2:0] CMD_JOIN  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_READ  = 3'd2;
    localparam logic [2:0] CMD_LEAVE = 3'd3;
    localparam logic [2:0] CMD_QUERY = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOROOM = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_NOID   = 2'd3;

    typedef logic [RPTR_W-1:0] rptr_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [4:0]  port;
        logic [31:0] payload;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_word;
        logic [4:0]  assigned_port;
        logic [4:0]  peer_count;
        logic        any_peer_full;
        logic        has_data;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic wstep;
        logic rcapture;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic go_loop;
        logic go_read;
        logic idx_last;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/brq_ram.sv
`default_nettype none

module brq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/brq_dp.sv
`default_nettype none

module brq_dp
    import brq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire req_t     req,
    input  wire dp_cmd_t  cmd,
    output dp_stat_t      stat,
    output rsp_t          rsp
);

    function automatic rptr_t ring_next(rptr_t p);
        return (p == RPTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // item registers
    logic [2:0]        cmd_reg;
    logic [4:0]        me_reg;
    logic [WORD_W-1:0] word_reg;
    logic [1:0]        status_reg;
    logic [WORD_W-1:0] rd_reg;
    logic [4:0]        assigned_reg;
    rsp_t              rsp_reg;

    // queue state
    logic [PORTS-1:0]  active_reg;
    logic [ID_W-1:0]   next_id_reg;
    logic [ID_W-1:0]   act_cnt_reg;
    rptr_t             head_reg [PORTS];
    rptr_t             tail_reg [PORTS];
    logic [PORTS-1:0]  full_reg;
    logic [PORTS-1:0]  empty_reg;
    logic [PIDX_W-1:0] idx_reg;

    logic              own;
    logic [PIDX_W-1:0] me_idx;
    logic [PORTS-1:0]  me_mask;
    logic [PORTS-1:0]  peers;
    logic              peer_full;
    logic              self_act;
    logic [PIDX_W-1:0] sel_idx;
    rptr_t             sel_head;
    rptr_t             sel_tail;
    rptr_t             head_adv;
    rptr_t             tail_adv;
    logic [ID_W-1:0]   peer_cnt;
    logic              id_free;
    logic [RAM_AW-1:0] ram_addr;
    logic              ram_we;
    logic [WORD_W-1:0] ram_rdata;

    assign own       = (32'(me_reg) < PORTS);
    assign me_idx    = me_reg[PIDX_W-1:0];
    assign me_mask   = own ? ({{(PORTS-1){1'b0}}, 1'b1} << me_idx) : '0;
    assign peers     = active_reg & ~me_mask;
    assign peer_full = |(peers & full_reg);
    assign self_act  = own & active_reg[me_idx];
    assign peer_cnt  = act_cnt_reg - ID_W'(self_act);
    assign id_free   = (32'(next_id_reg) < PORTS);

    assign sel_idx   = cmd.wstep ? idx_reg : me_idx;
    assign sel_head  = head_reg[sel_idx];
    assign sel_tail  = tail_reg[sel_idx];
    assign head_adv  = ring_next(sel_head);
    assign tail_adv  = ring_next(sel_tail);

    assign ram_addr  = RAM_AW'(sel_idx) * RAM_AW'(RING_DEPTH)
                     + RAM_AW'(cmd.wstep ? sel_tail : sel_head);
    assign ram_we    = cmd.wstep & peers[idx_reg];

    brq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (cmd.exec),
        .addr  (ram_addr),
        .wdata (word_reg),
        .rdata (ram_rdata)
    );

    assign stat.go_loop  = (cmd_reg == CMD_WRITE) && (|peers) && !peer_full;
    assign stat.go_read  = (cmd_reg == CMD_READ) && own && !empty_reg[me_idx];
    assign stat.idx_last = (idx_reg == PIDX_W'(PORTS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg      <= req.cmd;
            me_reg       <= req.port;
            word_reg     <= req.payload[WORD_W-1:0];
            status_reg   <= ST_OK;
            rd_reg       <= '0;
            assigned_reg <= '0;
        end
        if (cmd.exec)
        begin
            case (cmd_reg)
                CMD_JOIN:
                begin
                    if (id_free)
                    begin
                        assigned_reg <= 5'(next_id_reg);
                        me_reg       <= 5'(next_id_reg);
                    end
                    else
                    begin
                        status_reg <= ST_NOID;
                    end
                end
                CMD_WRITE:
                begin
                    if ((|peers) && peer_full)
                    begin
                        status_reg <= ST_NOROOM;
                    end
                end
                CMD_READ:
                begin
                    if (!stat.go_read)
                    begin
                        status_reg <= ST_EMPTY;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.rcapture)
        begin
            rd_reg <= ram_rdata;
        end
        if (cmd.finish)
        begin
            rsp_reg.status        <= status_reg;
            rsp_reg.read_word     <= 32'(rd_reg);
            rsp_reg.assigned_port <= assigned_reg;
            rsp_reg.peer_count    <= 5'(peer_cnt);
            rsp_reg.any_peer_full <= peer_full;
            rsp_reg.has_data      <= own & ~empty_reg[me_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= '0;
            next_id_reg <= '0;
            act_cnt_reg <= '0;
            full_reg    <= '0;
            empty_reg   <= '1;
            idx_reg     <= '0;
            for (int i = 0; i < PORTS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.exec)
            begin
                idx_reg <= '0;
                case (cmd_reg)
                    CMD_JOIN:
                    begin
                        if (id_free)
                        begin
                            next_id_reg                          <= next_id_reg + 1'b1;
                            active_reg[next_id_reg[PIDX_W-1:0]] <= 1'b1;
                            act_cnt_reg                          <= act_cnt_reg + 1'b1;
                        end
                    end
                    CMD_READ:
                    begin
                        if (stat.go_read)
                        begin
                            head_reg[me_idx]  <= head_adv;
                            full_reg[me_idx]  <= 1'b0;
                            empty_reg[me_idx] <= (head_adv == sel_tail);
                        end
                    end
                    CMD_LEAVE:
                    begin
                        if (own)
                        begin
                            active_reg[me_idx] <= 1'b0;
                            act_cnt_reg        <= act_cnt_reg - ID_W'(self_act);
                            head_reg[me_idx]   <= sel_tail;
                            full_reg[me_idx]   <= 1'b0;
                            empty_reg[me_idx]  <= 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.wstep)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (peers[idx_reg])
                begin
                    tail_reg[idx_reg]  <= tail_adv;
                    full_reg[idx_reg]  <= (ring_next(tail_adv) == sel_head);
                    empty_reg[idx_reg] <= 1'b0;
                end
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// File: rtl/core/brq_ctrl.sv
`default_nettype none

module brq_ctrl
    import brq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_WLOOP = 3'd2;
    localparam logic [2:0] S_RWAIT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.go_loop)
                begin
                    state_next = S_WLOOP;
                end
                else if (stat.go_read)
                begin
                    state_next = S_RWAIT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WLOOP:
            begin
                cmd.wstep = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_RWAIT:
            begin
                cmd.rcapture = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/core/broadcast_ring_queue_top.sv
`default_nettype none

// Multicast queue for up to PORTS ports, each with its own ring of handle words held
// in one shared single-port memory (no clearing after reset). Commands are join, write,
// read, leave and peer query; every command gives exactly one result. One command is
// worked at a time: join, leave and query pass the load, execute and done states, a read
// that finds data also waits in a read-wait state, and a write that stores steps the
// memory port through every ring in turn, one per cycle. A new command is taken as soon
// as the previous result sits in the output register, even while it is still stalled.

module broadcast_ring_queue_top
    import brq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    brq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    brq_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// File: rtl/core/brq_checker.sv
`default_nettype none

module brq_checker
    import brq_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_stall,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    // one command in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second transfer taken while busy");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_EMPTY) |-> (rsp.read_word == '0) && !rsp.has_data)
        else $error("empty read carries data");

    a_assign: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> (rsp.assigned_port == '0))
        else $error("failed command reports a port id");

endmodule

bind broadcast_ring_queue_top brq_checker u_chk (.*);

`default_nettype wire
